@@ design/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Shared types and constants of the clock frame replacer.
// ----------------------------------------------------------------------------
package cfr_pkg;

	// Pool size and the widths that follow from it.
	localparam int FRAMES  = 64;
	localparam int FRAME_W = $clog2(FRAMES);
	localparam int CNT_W   = $clog2(FRAMES + 1);

	// Request kinds. The fourth code is undefined and changes no state.
	localparam logic [1:0] KIND_TOUCH    = 2'd0;
	localparam logic [1:0] KIND_ALLOCATE = 2'd1;
	localparam logic [1:0] KIND_REPLACE  = 2'd2;

	// One request.
	typedef struct packed {
		logic [1:0]         kind;
		logic [FRAME_W-1:0] frame;
	} in_item_t;

	// One result.
	typedef struct packed {
		logic [FRAME_W-1:0] chosen_frame;
		logic               evicted;
	} out_item_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;           // register an accepted request
		logic finish_direct;  // deliver a result that needs no sweep
		logic sweep_step;     // clear the bit at the hand and move past it
		logic finish_victim;  // deliver the frame at the hand as the victim
	} cfr_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic needs_sweep;    // registered request must take a clock victim
		logic ref_set;        // reference bit at the hand is set
		logic out_free;       // output register can take a result this cycle
	} cfr_status_t;

endpackage

@@ design/cfr_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfr_ctrl
// Controller of the clock frame replacer: accepts a request, then either
// finishes it at once or steps the clock sweep until a victim turns up.
// ----------------------------------------------------------------------------
module cfr_ctrl
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  cfr_status_t status,
	output cfr_cmd_t    cmd,
	output logic        busy
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_EXEC  = 3'b010,
		S_SWEEP = 3'b100
	} state_t;

	state_t state_q;
	state_t state_next;

	// The block takes a new request only when it holds none.
	assign busy = (state_q != S_IDLE);

	// Next state and commands.
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					state_next = S_EXEC;
				end
			end
			S_EXEC: begin
				if (status.needs_sweep) begin
					state_next = S_SWEEP;
				end else if (status.out_free) begin
					cmd.finish_direct = 1'b1;
					state_next        = S_IDLE;
				end
			end
			S_SWEEP: begin
				if (status.ref_set) begin
					cmd.sweep_step = 1'b1;
				end else if (status.out_free) begin
					cmd.finish_victim = 1'b1;
					state_next        = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

endmodule

@@ design/cfr_dp.sv @@
// ----------------------------------------------------------------------------
// cfr_dp
// Datapath of the clock frame replacer: reference bits, clock hand, count of
// never-used frames, the registered request and the output register.
// ----------------------------------------------------------------------------
module cfr_dp
	import cfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  in_item_t    in_data,
	input  logic        out_stall,
	input  cfr_cmd_t    cmd,
	output cfr_status_t status,
	output logic        out_valid,
	output out_item_t   out_data
);

	localparam logic [CNT_W-1:0]   FRAMES_C = CNT_W'(FRAMES);
	localparam logic [FRAME_W-1:0] LAST_C   = FRAME_W'(FRAMES - 1);

	logic [FRAMES-1:0]  ref_q;
	logic [FRAME_W-1:0] hand_q;
	logic [CNT_W-1:0]   unused_q;
	logic               out_valid_q;
	in_item_t           item_q;
	out_item_t          out_data_q;

	logic               alloc_new;
	logic [CNT_W-1:0]   alloc_idx;
	logic [FRAME_W-1:0] hand_next;
	logic [FRAME_W-1:0] direct_frame;

	// An allocate takes a fresh frame while any remain; otherwise it sweeps.
	assign alloc_new   = (item_q.kind == KIND_ALLOCATE) && (unused_q != '0);
	assign alloc_idx   = FRAMES_C - unused_q;
	assign hand_next   = (hand_q == LAST_C) ? '0 : hand_q + 1'b1;
	assign direct_frame = alloc_new ? alloc_idx[FRAME_W-1:0] : item_q.frame;

	// Status towards the controller.
	assign status.needs_sweep = (item_q.kind == KIND_REPLACE) ||
		((item_q.kind == KIND_ALLOCATE) && (unused_q == '0));
	assign status.ref_set     = ref_q[hand_q];
	assign status.out_free    = !out_valid_q || !out_stall;

	// Replacement state and output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q       <= '0;
			hand_q      <= '0;
			unused_q    <= FRAMES_C;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.finish_direct) begin
				if (item_q.kind == KIND_TOUCH || alloc_new) begin
					ref_q[direct_frame] <= 1'b1;
				end
				if (alloc_new) begin
					unused_q <= unused_q - 1'b1;
				end
			end
			if (cmd.sweep_step) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_next;
			end
			if (cmd.finish_victim) begin
				ref_q[hand_q] <= 1'b1;
				hand_q        <= hand_next;
			end
			if (cmd.finish_direct || cmd.finish_victim) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
		end
		if (cmd.finish_direct) begin
			out_data_q.chosen_frame <= direct_frame;
			out_data_q.evicted      <= 1'b0;
		end else if (cmd.finish_victim) begin
			out_data_q.chosen_frame <= hand_q;
			out_data_q.evicted      <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

@@ design/clock_frame_replacer_core.sv @@
// ----------------------------------------------------------------------------
// clock_frame_replacer_core
// Buffer pool frame chooser under the clock (second-chance) policy.
// ----------------------------------------------------------------------------
// Requests are taken one at a time. A touch, an allocate that still finds a
// never-used frame, or an undefined kind is first registered and then gives
// its result. A request that takes a clock victim is registered, then the
// hand sweeps past each set reference bit and the frame at the first clear
// one is the victim; the sweep reads and clears one reference bit per cycle.
// The result waits in an output register, so a stall on the output only
// delays the next request once a second result is ready.
// ----------------------------------------------------------------------------
module clock_frame_replacer_core
	import cfr_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data
);

	cfr_cmd_t    cmd;
	cfr_status_t status;
	logic        busy;

	// Sequencing of each request.
	cfr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd),
		.busy     (busy)
	);

	// Reference bits, hand and result register.
	cfr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

	assign in_stall = busy;

endmodule

@@ design/cfr_checker.sv @@
// ----------------------------------------------------------------------------
// cfr_checker
// Port-level checks on the clock frame replacer, bound to the top level.
// ----------------------------------------------------------------------------
module cfr_checker
	import cfr_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// A stalled request stays offered and unchanged.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
		else $error("request withdrawn or changed while stalled");

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result withdrawn while stalled");

	// A stalled result does not change.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("result changed while stalled");

	// After a transfer in, the block holds off the next request.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second request taken in the cycle after a transfer");

	// A fresh result appears only while a request was being worked on.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared with no request in progress");

endmodule

bind clock_frame_replacer_core cfr_checker u_cfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
